@@ rtl/world_point_to_pixel_projection_defines.svh @@
// Assertion macros shared by the projection checker.
// No dependencies; included by files that assert.
`ifndef WORLD_POINT_TO_PIXEL_PROJECTION_DEFINES_SVH
`define WORLD_POINT_TO_PIXEL_PROJECTION_DEFINES_SVH

// Clocked assertion, disabled while reset is high
`define WPPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define WPPP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/wppp_pkg.sv @@
// Package for the world point to pixel projection block: widths, register
// indexes, reset values and pipeline types. No dependencies.
`timescale 1ns / 1ps

package wppp_pkg;

   localparam int CoordW   = 20;  // world and depth coordinates
   localparam int PixW     = 16;  // pixel and intrinsics fields
   localparam int RotW     = 16;  // rotation entry, Q2.14
   localparam int RotFrac  = 14;
   localparam int ProdW    = CoordW + RotW;       // one rotation product
   localparam int CamW     = 38;                  // camera coordinate, exact
   localparam int MagW     = CamW - 1;            // magnitude of a camera coordinate
   localparam int NumW     = MagW + PixW;         // |coord| * focal
   localparam int QuoW     = 18;                  // quotient bits before saturation
   localparam int RemW     = 58;                  // remainder, holds depth << QuoW
   localparam int SumW     = 20;                  // signed quotient plus center
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 60;

   typedef enum logic [CsrIdxW-1:0] {
      REG_FOCAL_X     = 3'd0,
      REG_FOCAL_Y     = 3'd1,
      REG_CENTER_X    = 3'd2,
      REG_CENTER_Y    = 3'd3,
      REG_ROT_ROW0    = 3'd4,
      REG_ROT_ROW1    = 3'd5,
      REG_ROT_ROW2    = 3'd6,
      REG_TRANSLATION = 3'd7
   } csr_index_type;

   localparam logic [15:0] FocalReset   = 16'd8192;
   localparam logic [15:0] CenterXReset = 16'd5120;
   localparam logic [15:0] CenterYReset = 16'd3840;
   localparam logic [47:0] RotRow0Reset = 48'h0000_0000_4000;
   localparam logic [47:0] RotRow1Reset = 48'h0000_4000_0000;
   localparam logic [47:0] RotRow2Reset = 48'h4000_0000_0000;

   // Numerator stage: magnitudes, signs and divisor
   typedef struct packed {
      logic [NumW-1:0]   num_u;
      logic [NumW-1:0]   num_v;
      logic              neg_u;
      logic              neg_v;
      logic [MagW-1:0]   divisor;
      logic              front;
      logic [CoordW-1:0] depth;
   } num_type;

   // Divider stage payload
   typedef struct packed {
      logic [RemW-1:0]   rem_u;
      logic [RemW-1:0]   rem_v;
      logic [QuoW-1:0]   quo_u;
      logic [QuoW-1:0]   quo_v;
      logic              ovf_u;
      logic              ovf_v;
      logic              neg_u;
      logic              neg_v;
      logic [MagW-1:0]   divisor;
      logic              front;
      logic [CoordW-1:0] depth;
   } div_type;

endpackage

@@ rtl/wppp_req_if.sv @@
// Input and result channel interfaces of the projection block.
// Depends on wppp_pkg for field widths.
`timescale 1ns / 1ps

interface wppp_req_if import wppp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] world_x;
   logic signed [CoordW-1:0] world_y;
   logic signed [CoordW-1:0] world_z;
   modport source (output valid, world_x, world_y, world_z, input ready);
   modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wppp_rsp_if import wppp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [PixW-1:0]   pixel_u;
   logic signed [PixW-1:0]   pixel_v;
   logic signed [CoordW-1:0] camera_depth;
   logic                     in_front;
   modport source (output valid, pixel_u, pixel_v, camera_depth, in_front, input ready);
   modport sink   (input valid, pixel_u, pixel_v, camera_depth, in_front, output ready);
endinterface

@@ rtl/world_point_to_pixel_projection.sv @@
// World point to pixel projection: pipelined from accept to result,
// throughput one item per cycle; a stall holds every stage in place.
// Pipeline: 9 rotation products, sums, depth and focal multiply, rounding
// offset, quotient range check, one quotient bit per stage (18), output add.
// Synchronous active-high reset empties the pipeline and loads the identity
// pose, zero translation, focal 512.0 and principal point (320.0, 240.0).
`timescale 1ns / 1ps

module world_point_to_pixel_projection import wppp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   wppp_req_if.sink            req_ch,
   wppp_rsp_if.source          rsp_ch,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers
   logic [PixW-1:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [47:0]     rot_ff [3];
   logic [59:0]     trans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FocalReset;
         focal_y_ff  <= FocalReset;
         center_x_ff <= CenterXReset;
         center_y_ff <= CenterYReset;
         rot_ff[0]   <= RotRow0Reset;
         rot_ff[1]   <= RotRow1Reset;
         rot_ff[2]   <= RotRow2Reset;
         trans_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_FOCAL_X:     focal_x_ff  <= csr_wdata[15:0];
            REG_FOCAL_Y:     focal_y_ff  <= csr_wdata[15:0];
            REG_CENTER_X:    center_x_ff <= csr_wdata[15:0];
            REG_CENTER_Y:    center_y_ff <= csr_wdata[15:0];
            REG_ROT_ROW0:    rot_ff[0]   <= csr_wdata[47:0];
            REG_ROT_ROW1:    rot_ff[1]   <= csr_wdata[47:0];
            REG_ROT_ROW2:    rot_ff[2]   <= csr_wdata[47:0];
            REG_TRANSLATION: trans_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Global advance: the whole pipeline moves unless the output item is stuck
   logic out_vld_ff;
   logic adv;
   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: rotation products
   logic                     s1_vld_ff;
   logic signed [ProdW-1:0]  prod_ff [3][3];
   logic signed [CoordW-1:0] trn_ff  [3];
   logic signed [CoordW-1:0] wpt     [3];

   assign wpt[0] = req_ch.world_x;
   assign wpt[1] = req_ch.world_y;
   assign wpt[2] = req_ch.world_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(rot_ff[r][16*c +: RotW]) * wpt[c];
            end
            trn_ff[r] <= $signed(trans_ff[20*r +: CoordW]);
         end
      end
   end

   // Stage 2: camera coordinates c = R*w + t, exact
   logic              s2_vld_ff;
   logic signed [CamW-1:0] cam_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            cam_ff[r] <= CamW'(prod_ff[r][0]) + CamW'(prod_ff[r][1]) + CamW'(prod_ff[r][2])
                       + $signed({trn_ff[r][CoordW-1], trn_ff[r][CoordW-1],
                                  trn_ff[r][CoordW-1], trn_ff[r][CoordW-1],
                                  trn_ff[r], {RotFrac{1'b0}}});
         end
      end
   end

   // Stage 3: depth, front test and focal multiply
   logic                  s3_vld_ff;
   num_type               s3_ff;
   logic signed [CamW-1:0] cz_rnd;
   logic signed [CamW-RotFrac-1:0] depth_wide;
   logic [CamW-1:0]       abs_u, abs_v;
   logic                  front3;
   logic [CoordW-1:0]     depth_sat;

   always_comb begin
      cz_rnd     = cam_ff[2] + CamW'(1 << (RotFrac - 1));
      depth_wide = cz_rnd[CamW-1:RotFrac];
      front3     = !depth_wide[CamW-RotFrac-1] && (depth_wide != '0);
      abs_u      = cam_ff[0][CamW-1] ? CamW'(-cam_ff[0]) : cam_ff[0];
      abs_v      = cam_ff[1][CamW-1] ? CamW'(-cam_ff[1]) : cam_ff[1];
      // Saturate depth when the top bits do not all match the sign
      if (!depth_wide[CamW-RotFrac-1] && (depth_wide[CamW-RotFrac-2:CoordW-1] != '0)) begin
         depth_sat = {1'b0, {(CoordW-1){1'b1}}};
      end else if (depth_wide[CamW-RotFrac-1] &&
                   (depth_wide[CamW-RotFrac-2:CoordW-1] != '1)) begin
         depth_sat = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
         depth_sat = depth_wide[CoordW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff.num_u   <= abs_u[MagW-1:0] * focal_x_ff;
         s3_ff.num_v   <= abs_v[MagW-1:0] * focal_y_ff;
         s3_ff.neg_u   <= cam_ff[0][CamW-1];
         s3_ff.neg_v   <= cam_ff[1][CamW-1];
         s3_ff.divisor <= front3 ? cam_ff[2][MagW-1:0] : MagW'(1);
         s3_ff.front   <= front3;
         s3_ff.depth   <= depth_sat;
      end
   end

   // Stage 4: add half the divisor for round to nearest, ties away from zero
   logic    s4_vld_ff;
   div_type s4_ff;
   logic [RemW-1:0] half_div;

   assign half_div = RemW'(s3_ff.divisor >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff.rem_u   <= RemW'(s3_ff.num_u) + half_div;
         s4_ff.rem_v   <= RemW'(s3_ff.num_v) + half_div;
         s4_ff.quo_u   <= '0;
         s4_ff.quo_v   <= '0;
         s4_ff.ovf_u   <= 1'b0;
         s4_ff.ovf_v   <= 1'b0;
         s4_ff.neg_u   <= s3_ff.neg_u;
         s4_ff.neg_v   <= s3_ff.neg_v;
         s4_ff.divisor <= s3_ff.divisor;
         s4_ff.front   <= s3_ff.front;
         s4_ff.depth   <= s3_ff.depth;
      end
   end

   // Stage 5: flag quotients too large for the QuoW quotient bits
   logic    div_vld_ff [QuoW+1];
   div_type div_ff     [QuoW+1];
   logic [RemW-1:0] top_div;
   div_type         div0_in;

   assign top_div = RemW'(s4_ff.divisor) << QuoW;

   always_comb begin
      div0_in       = s4_ff;
      div0_in.ovf_u = s4_ff.rem_u >= top_div;
      div0_in.ovf_v = s4_ff.rem_v >= top_div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div0_in;
      end
   end

   // Divider stages: one restoring quotient bit per stage, MSB first
   for (genvar k = 0; k < QuoW; k++) begin : g_div
      localparam int Bit = QuoW - 1 - k;
      logic [RemW-1:0] shifted;
      logic            take_u, take_v;
      div_type         stage_in;

      assign shifted = RemW'(div_ff[k].divisor) << Bit;
      assign take_u  = div_ff[k].rem_u >= shifted;
      assign take_v  = div_ff[k].rem_v >= shifted;

      always_comb begin
         stage_in            = div_ff[k];
         stage_in.rem_u      = take_u ? div_ff[k].rem_u - shifted : div_ff[k].rem_u;
         stage_in.rem_v      = take_v ? div_ff[k].rem_v - shifted : div_ff[k].rem_v;
         stage_in.quo_u[Bit] = take_u;
         stage_in.quo_v[Bit] = take_v;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[k+1] <= div_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= stage_in;
         end
      end
   end

   // Output stage: apply sign, add principal point, saturate; zero behind the camera
   function automatic logic [PixW-1:0] pix_out(input logic [QuoW-1:0] quo, input logic neg,
                                               input logic ovf, input logic [PixW-1:0] ctr);
      logic signed [SumW-1:0] qs;
      logic signed [SumW-1:0] sum;
      qs  = neg ? -$signed(SumW'(quo)) : $signed(SumW'(quo));
      sum = qs + $signed(SumW'(ctr));
      if (ovf) begin
         return neg ? {1'b1, {(PixW-1){1'b0}}} : {1'b0, {(PixW-1){1'b1}}};
      end else if (sum > $signed(SumW'(32767))) begin
         return {1'b0, {(PixW-1){1'b1}}};
      end else if (sum < -$signed(SumW'(32768))) begin
         return {1'b1, {(PixW-1){1'b0}}};
      end
      return sum[PixW-1:0];
   endfunction

   logic [PixW-1:0]   u_ff, v_ff;
   logic [CoordW-1:0] depth_ff;
   logic              front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= div_vld_ff[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff     <= div_ff[QuoW].front ?
                     pix_out(div_ff[QuoW].quo_u, div_ff[QuoW].neg_u,
                             div_ff[QuoW].ovf_u, center_x_ff) : '0;
         v_ff     <= div_ff[QuoW].front ?
                     pix_out(div_ff[QuoW].quo_v, div_ff[QuoW].neg_v,
                             div_ff[QuoW].ovf_v, center_y_ff) : '0;
         depth_ff <= div_ff[QuoW].depth;
         front_ff <= div_ff[QuoW].front;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.pixel_u      = u_ff;
   assign rsp_ch.pixel_v      = v_ff;
   assign rsp_ch.camera_depth = depth_ff;
   assign rsp_ch.in_front     = front_ff;

endmodule

@@ rtl/wppp_checker.sv @@
// Port-level checks for the projection block, bound to the top level.
// Depends on wppp_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "world_point_to_pixel_projection_defines.svh"

module wppp_checker import wppp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [PixW-1:0]   pixel_u,
   input logic [PixW-1:0]   pixel_v,
   input logic [CoordW-1:0] camera_depth,
   input logic              in_front
);

   // Reset empties the pipeline
   `WPPP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "item shown after reset")

   // Points behind the camera report a zero pixel
   `WPPP_ASSERT(a_behind_zero, clock, reset,
                rsp_valid && !in_front |-> pixel_u == '0 && pixel_v == '0,
                "pixel not zero behind camera")

   // Front flag agrees with the sign of the reported depth
   `WPPP_ASSERT(a_front_depth, clock, reset,
                rsp_valid |-> in_front == (!camera_depth[CoordW-1] && camera_depth != '0),
                "front flag disagrees with depth")

   // A stalled item holds
   `WPPP_ASSERT(a_stall_hold, clock, reset,
                rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_u) &&
                $stable(pixel_v) && $stable(camera_depth),
                "stalled item changed")

endmodule

bind world_point_to_pixel_projection wppp_checker u_wppp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .pixel_u      (rsp_ch.pixel_u),
   .pixel_v      (rsp_ch.pixel_v),
   .camera_depth (rsp_ch.camera_depth),
   .in_front     (rsp_ch.in_front)
);
